// ===== rtl/core/vm_source_lexer_macros.svh =====
// Assertion macros shared by the source lexer RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef VM_SOURCE_LEXER_MACROS_SVH
`define VM_SOURCE_LEXER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check prop at every rising clk_i edge, quiet while rst_ni is low.
`define VSL_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");

// Check prop at every rising clk_i edge, reset included.
`define VSL_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed");

`else

`define VSL_ASSERT_RST(label, prop)
`define VSL_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ===== rtl/core/vsl_pkg.sv =====
// Types and constants of the source lexer: token kinds, run classes,
// keyword table and the result record. Depends on nothing.
package vsl_pkg;

  localparam int unsigned TEXT_W   = 64;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned NUM_KW   = 7;
  localparam int unsigned FIFO_DEPTH = 4;

  typedef enum logic [3:0] {
    K_PUSH    = 4'd0,
    K_POP     = 4'd1,
    K_DUP     = 4'd2,
    K_ADD     = 4'd3,
    K_IFEQ    = 4'd4,
    K_JUMP    = 4'd5,
    K_PRINT   = 4'd6,
    K_NUMBER  = 4'd7,
    K_NEWLINE = 4'd8,
    K_BLANKS  = 4'd9,
    K_END     = 4'd10,
    K_ERROR   = 4'd11
  } kind_e;

  // Class of the open run.
  localparam logic [1:0] CL_IDLE  = 2'd0;
  localparam logic [1:0] CL_BLANK = 2'd1;
  localparam logic [1:0] CL_DIGIT = 2'd2;
  localparam logic [1:0] CL_LOWER = 2'd3;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;

  // Keywords packed first character in the low byte, in kind order.
  localparam logic [TEXT_W-1:0] KEYWORD_PACK [NUM_KW] = '{
    64'h0000_0000_6873_7570,  // push
    64'h0000_0000_0070_6f70,  // pop
    64'h0000_0000_0070_7564,  // dup
    64'h0000_0000_0064_6461,  // add
    64'h0000_0000_7165_6669,  // ifeq
    64'h0000_0000_706d_756a,  // jump
    64'h0000_0074_6e69_7270   // print
  };

  typedef struct packed {
    kind_e             kind;
    logic [LEN_W-1:0]  text_len;
    logic [TEXT_W-1:0] text_bytes;
    logic              last;
  } res_t;

  // What one byte produces: number of results (0..2) and the results.
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } step_out_t;

endpackage

// ===== rtl/core/vsl_lex_step.sv =====
// One lexer step: from the open run and one byte, the next run and the
// results the byte completes. Combinational. Depends on vsl_pkg.
module vsl_lex_step #(
  parameter int unsigned MAX_TEXT_LEN = 8
) (
  input  logic [1:0]                  run_class_i,
  input  logic [vsl_pkg::TEXT_W-1:0]  run_text_i,
  input  logic [vsl_pkg::LEN_W-1:0]   run_len_i,
  input  logic [vsl_pkg::CHAR_W-1:0]  char_i,
  output logic [1:0]                  run_class_o,
  output logic [vsl_pkg::TEXT_W-1:0]  run_text_o,
  output logic [vsl_pkg::LEN_W-1:0]   run_len_o,
  output vsl_pkg::step_out_t          step_o
);
  import vsl_pkg::*;

  logic  is_blank, is_digit, is_lower, is_term, room, extend, do_close;
  logic  kw_hit, start_emit;
  kind_e kw_kind;
  res_t  close_res, start_res;
  logic [1:0]        start_cls;
  logic [TEXT_W-1:0] start_text;
  logic [LEN_W-1:0]  start_len;

  always_comb begin
    is_blank = (char_i == CH_SPACE) || (char_i == CH_TAB);
    is_digit = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
    is_lower = (char_i >= CH_LC_A) && (char_i <= CH_LC_Z);
    is_term  = is_blank || (char_i == CH_LF) || (char_i == CH_NUL);
    room     = run_len_i < LEN_W'(MAX_TEXT_LEN);

    extend = ((run_class_i == CL_BLANK) && is_blank) ||
             ((run_class_i == CL_DIGIT) && is_digit && room) ||
             ((run_class_i == CL_LOWER) && is_lower && room);
    do_close = (run_class_i != CL_IDLE) && !extend;

    // keyword match on the whole packed text
    kw_hit  = 1'b0;
    kw_kind = K_ERROR;
    for (int i = NUM_KW - 1; i >= 0; i--) begin
      if (run_text_i == KEYWORD_PACK[i]) begin
        kw_hit  = 1'b1;
        kw_kind = kind_e'(LEN_W'(i));
      end
    end

    close_res            = '0;
    close_res.kind       = K_ERROR;
    close_res.text_len   = run_len_i;
    close_res.text_bytes = run_text_i;
    case (run_class_i)
      CL_BLANK: begin
        close_res.kind       = K_BLANKS;
        close_res.text_len   = '0;
        close_res.text_bytes = '0;
      end
      CL_DIGIT: close_res.kind = is_term ? K_NUMBER : K_ERROR;
      CL_LOWER: close_res.kind = (is_term && kw_hit) ? kw_kind : K_ERROR;
      default:  close_res.kind = K_ERROR;
    endcase

    // token started by the byte itself
    start_res  = '0;
    start_emit = 1'b0;
    start_cls  = CL_IDLE;
    start_text = '0;
    start_len  = '0;
    if (char_i == CH_NUL) begin
      start_emit     = 1'b1;
      start_res.kind = K_END;
    end else if (char_i == CH_LF) begin
      start_emit     = 1'b1;
      start_res.kind = K_NEWLINE;
    end else if (is_blank) begin
      start_cls = CL_BLANK;
    end else if (is_digit || is_lower) begin
      start_cls              = is_digit ? CL_DIGIT : CL_LOWER;
      start_text[CHAR_W-1:0] = char_i;
      start_len              = LEN_W'(1);
    end else begin
      start_emit     = 1'b1;
      start_res.kind = K_ERROR;
    end

    step_o = '0;
    if (extend) begin
      run_class_o = run_class_i;
      run_text_o  = run_text_i;
      if (run_class_i != CL_BLANK) begin
        run_text_o[CHAR_W*run_len_i[2:0] +: CHAR_W] = char_i;
      end
      run_len_o = (run_class_i == CL_BLANK) ? run_len_i : run_len_i + LEN_W'(1);
    end else begin
      run_class_o  = start_cls;
      run_text_o   = start_text;
      run_len_o    = start_len;
      step_o.count = {1'b0, do_close} + {1'b0, start_emit};
      step_o.r0    = do_close ? close_res : start_res;
      step_o.r0.last = !(do_close && start_emit);
      step_o.r1      = start_res;
      step_o.r1.last = 1'b1;
    end
  end

endmodule

// ===== rtl/core/vm_source_lexer.sv =====
// Streaming source lexer, top level: input register, lexer step and result queue.
// Depends on vsl_pkg, vsl_lex_step and vm_source_lexer_macros.svh.
//
// Takes one source byte per transfer on the input channel and delivers
// tokens on the output channel, one result per transfer. A byte is
// registered, then, once the queue has room for two results, the lexer step
// closes or extends the open run and pushes zero, one or two results into a
// four-entry result queue, which drives the output ports. A byte enters every
// cycle as long as the queue has room for two results; the output port moves
// one result per cycle while out_stall_i is low, so the sustained rate is one
// byte per cycle while bytes give at most one result each and the output is
// not stalled; a byte that gives two results (an open run closed by a
// newline, a NUL or an unrecognised byte) takes one more output transfer.
// A byte's results reach the output through the byte register and the
// result queue. Token text is packed first character in the low byte; last_o
// marks the final result of a byte. There is no clearing pass after reset.
`include "vm_source_lexer_macros.svh"

module vm_source_lexer #(
  parameter int unsigned MAX_TEXT_LEN = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [vsl_pkg::CHAR_W-1:0]  char_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [3:0]                  kind_o,
  output logic [vsl_pkg::LEN_W-1:0]   text_len_o,
  output logic [vsl_pkg::TEXT_W-1:0]  text_bytes_o,
  output logic                        last_o
);
  import vsl_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  // input register
  logic              in_full_q, in_full_d;
  logic [CHAR_W-1:0] char_q;

  // open run
  logic [1:0]        run_class_q, run_class_d;
  logic [TEXT_W-1:0] run_text_q, run_text_d;
  logic [LEN_W-1:0]  run_len_q, run_len_d;
  step_out_t         step;

  // result queue
  res_t             res_mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic proc, in_xfer, out_xfer;
  res_t head;

  // Process the held byte only when the queue can take two results.
  assign proc       = in_full_q && (cnt_q <= CNT_W'(FIFO_DEPTH - 2));
  assign in_stall_o = in_full_q && !proc;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign head         = res_mem[rd_ptr_q];
  assign out_valid_o  = (cnt_q != '0);
  assign out_xfer     = out_valid_o && !out_stall_i;
  assign kind_o       = head.kind;
  assign text_len_o   = head.text_len;
  assign text_bytes_o = head.text_bytes;
  assign last_o       = head.last;

  vsl_lex_step #(
    .MAX_TEXT_LEN(MAX_TEXT_LEN)
  ) u_step (
    .run_class_i(run_class_q),
    .run_text_i (run_text_q),
    .run_len_i  (run_len_q),
    .char_i     (char_q),
    .run_class_o(run_class_d),
    .run_text_o (run_text_d),
    .run_len_o  (run_len_d),
    .step_o     (step)
  );

  always_comb begin
    in_full_d = in_full_q;
    if (in_xfer) begin
      in_full_d = 1'b1;
    end else if (proc) begin
      in_full_d = 1'b0;
    end
    wr_ptr_d = wr_ptr_q;
    cnt_d    = cnt_q;
    if (proc) begin
      wr_ptr_d = wr_ptr_q + PTR_W'(step.count);
      cnt_d    = cnt_q + CNT_W'(step.count);
    end
    rd_ptr_d = out_xfer ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    if (out_xfer) begin
      cnt_d = cnt_d - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q   <= 1'b0;
      run_class_q <= CL_IDLE;
      run_text_q  <= '0;
      run_len_q   <= '0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
    end else begin
      in_full_q <= in_full_d;
      wr_ptr_q  <= wr_ptr_d;
      rd_ptr_q  <= rd_ptr_d;
      cnt_q     <= cnt_d;
      // advance the open run once per processed byte
      if (proc) begin
        run_class_q <= run_class_d;
        run_text_q  <= run_text_d;
        run_len_q   <= run_len_d;
      end
    end
  end

  // payload: byte holding register and queue entries
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      char_q <= char_in_i;
    end
    if (proc && (step.count != 2'd0)) begin
      res_mem[wr_ptr_q] <= step.r0;
    end
    if (proc && (step.count == 2'd2)) begin
      res_mem[wr_ptr_q + PTR_W'(1)] <= step.r1;
    end
  end

  // queue never holds more than its depth
  `VSL_ASSERT_RST(a_cnt_bound, cnt_q <= CNT_W'(FIFO_DEPTH))
  // a result that is not the last of its byte has its partner queued behind it
  `VSL_ASSERT_RST(a_pair_queued, (out_xfer && !last_o) |-> (cnt_q >= CNT_W'(2)))
  // the open run never outgrows the text limit
  `VSL_ASSERT_RST(a_len_bound, run_len_q <= LEN_W'(MAX_TEXT_LEN))
  // an idle or blank run holds no text
  `VSL_ASSERT_RST(a_idle_empty,
    ((run_class_q == CL_IDLE) || (run_class_q == CL_BLANK)) |->
      ((run_len_q == '0) && (run_text_q == '0)))
  // a held byte that cannot be processed blocks the next transfer
  `VSL_ASSERT_RST(a_hold_byte, (in_full_q && !proc) |=> (in_full_q && $stable(char_q)))

endmodule

// ===== bench/tb_vm_source_lexer.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the streaming source lexer vm_source_lexer.
// Depends on vsl_pkg and the RTL; holds its own token predictor and queue.

module tb_vm_source_lexer;
  import vsl_pkg::*;

  localparam int unsigned MAX_TEXT_LEN = 8;

  // Predicts the tokens of each transferred byte and checks delivered ones.
  class token_scoreboard;
    logic [1:0]        run_class;
    logic [TEXT_W-1:0] run_text;
    logic [LEN_W-1:0]  run_length;
    res_t              byte_tokens[$];
    res_t              expected_tokens[$];
    int unsigned       mismatches;

    function new();
      run_class  = CL_IDLE;
      run_text   = '0;
      run_length = '0;
      mismatches = 0;
    endfunction

    static function bit is_blank(logic [CHAR_W-1:0] c);
      return c == CH_SPACE || c == CH_TAB;
    endfunction

    static function bit is_digit(logic [CHAR_W-1:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    static function bit is_lower(logic [CHAR_W-1:0] c);
      return c >= CH_LC_A && c <= CH_LC_Z;
    endfunction

    static function bit is_term(logic [CHAR_W-1:0] c);
      return is_blank(c) || c == CH_LF || c == CH_NUL;
    endfunction

    function void emit(kind_e k, logic [LEN_W-1:0] len, logic [TEXT_W-1:0] text);
      res_t r;
      r.kind       = k;
      r.text_len   = len;
      r.text_bytes = text;
      r.last       = 1'b0;
      byte_tokens.push_back(r);
    endfunction

    function void append(logic [CHAR_W-1:0] c);
      run_text   = run_text | (TEXT_W'(c) << (run_length[2:0] * 8));
      run_length = run_length + 1'b1;
    endfunction

    // Close the open run; ok says the follower is a proper terminator.
    function void close_run(bit ok);
      kind_e k;
      k = K_ERROR;
      case (run_class)
        CL_BLANK: emit(K_BLANKS, '0, '0);
        CL_DIGIT: emit(ok ? K_NUMBER : K_ERROR, run_length, run_text);
        CL_LOWER: begin
          if (ok) begin
            for (int i = 0; i < NUM_KW; i++)
              if (run_text == KEYWORD_PACK[i]) k = kind_e'(i);
          end
          emit(k, run_length, run_text);
        end
        default: ;
      endcase
      run_class  = CL_IDLE;
      run_text   = '0;
      run_length = '0;
    endfunction

    // Advance the lexer state by one byte and queue the tokens it completes.
    function void lex_byte(logic [CHAR_W-1:0] c);
      bit room;
      room = run_length < MAX_TEXT_LEN;
      byte_tokens.delete();
      case (run_class)
        CL_BLANK: begin
          if (is_blank(c)) return;
          close_run(1'b1);
        end
        CL_DIGIT: begin
          if (is_digit(c) && room) begin
            append(c);
            return;
          end
          close_run(is_term(c));
        end
        CL_LOWER: begin
          if (is_lower(c) && room) begin
            append(c);
            return;
          end
          close_run(is_term(c));
        end
        default: ;
      endcase
      if (c == CH_NUL) emit(K_END, '0, '0);
      else if (c == CH_LF) emit(K_NEWLINE, '0, '0);
      else if (is_blank(c)) run_class = CL_BLANK;
      else if (is_digit(c)) begin
        run_class = CL_DIGIT;
        append(c);
      end else if (is_lower(c)) begin
        run_class = CL_LOWER;
        append(c);
      end else emit(K_ERROR, '0, '0);
      if (byte_tokens.size() > 0) byte_tokens[$].last = 1'b1;
      foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
    endfunction

    function void check_token(res_t got);
      res_t want;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected token kind %0d len %0d text %h last %0d",
                   $realtime, got.kind, got.text_len, got.text_bytes, got.last);
        return;
      end
      want = expected_tokens.pop_front();
      if (got.kind !== want.kind || got.text_len !== want.text_len ||
          got.text_bytes !== want.text_bytes || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: token mismatch (exp/act) kind %0d/%0d len %0d/%0d text %h/%h last %0d/%0d",
                   $realtime, want.kind, got.kind, want.text_len, got.text_len,
                   want.text_bytes, got.text_bytes, want.last, got.last);
      end
    endfunction

    function int unsigned pending();
      return expected_tokens.size();
    endfunction
  endclass

  logic                clk         = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid    = 1'b0;
  logic [CHAR_W-1:0]   char_in     = '0;
  logic                out_stall   = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [3:0]          kind;
  logic [LEN_W-1:0]    text_len;
  logic [TEXT_W-1:0]   text_bytes;
  logic                last;

  token_scoreboard sb = new();

  // Idle rates in percent, set per phase by the stimulus process.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned bytes_sent    = 0;
  bit          hold_request  = 1'b0;

  always #5 clk = ~clk;

  vm_source_lexer #(
    .MAX_TEXT_LEN (MAX_TEXT_LEN)
  ) uut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .char_in_i    (char_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .kind_o       (kind),
    .text_len_o   (text_len),
    .text_bytes_o (text_bytes),
    .last_o       (last)
  );

  // Offer one byte, idling beforehand at the phase's rate, and hold it until
  // the transfer. Valid is left high on return so back-to-back bytes need no
  // second assignment in the same step; a gap lowers it on the next call.
  task automatic send_byte(input logic [CHAR_W-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in  <= c;
    do @(posedge clk); while (in_stall);
    sb.lex_byte(c);
    bytes_sent++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Only proper terminators; NUL kept rare so texts stay long.
  function automatic logic [CHAR_W-1:0] random_terminator();
    int unsigned pick;
    pick = $urandom_range(19);
    if (pick < 10) return CH_SPACE;
    if (pick < 15) return CH_TAB;
    if (pick < 19) return CH_LF;
    return CH_NUL;
  endfunction

  // Send a digit or lowercase run of the given length.
  task automatic send_run(input bit letters, input int unsigned len);
    repeat (len) begin
      if (letters) send_byte(CHAR_W'(CH_LC_A + $urandom_range(25)));
      else send_byte(CHAR_W'(CH_ZERO + $urandom_range(9)));
    end
  endtask

  // One random token: mostly well-formed source, the rest broken runs and noise.
  task automatic send_random_token();
    int unsigned       pick;
    logic [TEXT_W-1:0] word;
    logic [CHAR_W-1:0] follower;
    pick = $urandom_range(99);
    if (pick < 30) begin
      word = KEYWORD_PACK[$urandom_range(NUM_KW - 1)];
      while (word[7:0] != CH_NUL) begin
        send_byte(word[7:0]);
        word = word >> 8;
      end
      send_byte(random_terminator());
    end else if (pick < 45) begin
      // an occasional overlong number exercises the text limit
      send_run(1'b0, ($urandom_range(19) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8));
      send_byte(random_terminator());
    end else if (pick < 55) begin
      send_run(1'b1, $urandom_range(1, 10));
      send_byte(random_terminator());
    end else if (pick < 65) begin
      repeat ($urandom_range(1, 4)) send_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
    end else if (pick < 72) begin
      send_byte(CH_LF);
    end else if (pick < 74) begin
      send_byte(CH_NUL);
    end else if (pick < 86) begin
      // word or number followed by something that is not a terminator
      send_run($urandom_range(1), $urandom_range(1, 8));
      do follower = CHAR_W'($urandom_range(255));
      while (token_scoreboard::is_term(follower));
      send_byte(follower);
    end else begin
      send_byte(CHAR_W'($urandom_range(255)));
    end
  endtask

  task automatic run_phase(input int unsigned n);
    int unsigned target;
    target = bytes_sent + n;
    while (bytes_sent < target) send_random_token();
  endtask

  // Stimulus: reset, directed text, then three random phases of idling.
  initial begin : stimulus
    int unsigned waited;
    waited = 0;
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    send_idle_pct = 11;
    recv_idle_pct = 57;
    // keyword, tab run, overlong number, bad follower with an unknown byte,
    // unknown word ended by newline, then the top byte value and end of text
    send_string("print\t123456789 ab+qz\n");
    send_byte(8'hFF);
    send_byte(CH_NUL);

    hold_request = 1'b1;
    run_phase(600);
    send_idle_pct = 57;
    recv_idle_pct = 11;
    run_phase(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    run_phase(600);
    in_valid <= 1'b0;

    // Drain: wait for every predicted token, then keep watching for strays.
    while (sb.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0d predicted tokens never delivered", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[vm_source_lexer] OK");
    end else begin
      $display("[vm_source_lexer] ERROR");
    end
    $finish;
  end

  // Receiver: check each transfer, then pick the stall for the next cycle.
  // A hold request drops it into a long stall so the block backs up.
  initial begin : receiver
    int unsigned hold_left;
    res_t        seen;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_ni && out_valid && !out_stall) begin
        seen = '{kind_e'(kind), text_len, text_bytes, last};
        sb.check_token(seen);
      end
      if (hold_request) begin
        hold_left    = 300;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("[vm_source_lexer] ERROR");
    $finish;
  end

endmodule
